// ===== rtl/sma_pkg.sv =====
// Package for the moving-average crossover detector.
// Holds field widths, signal codes and relation codes shared by all files.
// Depends on nothing.
package sma_pkg;

   // Widths of the item fields.
   localparam int PRICE_W     = 32;
   localparam int SIGNAL_W    = 2;
   localparam int SHORT_SUM_W = 37;
   localparam int LONG_SUM_W  = 38;

   typedef logic [SIGNAL_W-1:0] signal_type;
   typedef logic [1:0]          relation_type;

   // Trade signal codes carried on the result channel.
   localparam signal_type SIG_NONE = 2'd0;
   localparam signal_type SIG_BUY  = 2'd1;
   localparam signal_type SIG_SELL = 2'd2;

   // Relation of the short average to the long average.
   localparam relation_type REL_EQUAL   = 2'd0;
   localparam relation_type REL_LESS    = 2'd1;
   localparam relation_type REL_GREATER = 2'd2;

endpackage

// ===== rtl/sma_if.sv =====
// Valid/ready channel interfaces for the crossover detector.
// sma_req_if carries one price per item, sma_rsp_if one result per item.
// Depends on sma_pkg.
interface sma_req_if;
   import sma_pkg::*;

   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] price;

   modport source (output valid, output price, input ready);
   modport sink   (input valid, input price, output ready);
endinterface

interface sma_rsp_if;
   import sma_pkg::*;

   logic                   valid;
   logic                   ready;
   signal_type             signal;
   logic [PRICE_W-1:0]     price_out;
   logic [SHORT_SUM_W-1:0] short_sum;
   logic [LONG_SUM_W-1:0]  long_sum;

   modport source (output valid, output signal, output price_out, output short_sum,
                   output long_sum, input ready);
   modport sink   (input valid, input signal, input price_out, input short_sum,
                   input long_sum, output ready);
endinterface

// ===== rtl/sma_win.sv =====
// Price history shift line, running window sums and warm-up count.
// The effective window counts and the warm flag follow the stored state.
// Depends on sma_pkg.
module sma_win #(
   parameter int SHORT_WINDOW = 20,
   parameter int LONG_WINDOW  = 50
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            load,
   input  logic [sma_pkg::PRICE_W-1:0]                     price_in,
   output logic [sma_pkg::PRICE_W+$clog2(SHORT_WINDOW+1)-1:0] short_total,
   output logic [sma_pkg::PRICE_W+$clog2(LONG_WINDOW+1)-1:0]  long_total,
   output logic [$clog2(SHORT_WINDOW+1)-1:0]               n_short,
   output logic [$clog2(LONG_WINDOW+1)-1:0]                n_long,
   output logic                                            warm
);
   import sma_pkg::*;

   localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
   localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
   localparam int NS_W       = $clog2(SHORT_WINDOW + 1);
   localparam int NL_W       = $clog2(LONG_WINDOW + 1);
   localparam int S_TOT_W    = PRICE_W + NS_W;
   localparam int L_TOT_W    = PRICE_W + NL_W;

   logic [PRICE_W-1:0] hist_ff [HIST_DEPTH];
   logic [CNT_W-1:0]   seen_ff;
   logic [CNT_W-1:0]   seen_in;
   logic [S_TOT_W-1:0] short_total_ff;
   logic [S_TOT_W-1:0] short_total_in;
   logic [L_TOT_W-1:0] long_total_ff;
   logic [L_TOT_W-1:0] long_total_in;
   logic [PRICE_W-1:0] short_leave;
   logic [PRICE_W-1:0] long_leave;
   logic               short_full;
   logic               long_full;

   // A window is full once it has seen as many prices as it is long.
   assign short_full = (seen_ff >= CNT_W'(SHORT_WINDOW));
   assign long_full  = (seen_ff >= CNT_W'(LONG_WINDOW));

   // The price that drops out of each window; tap 0 holds the newest price.
   assign short_leave = short_full ? hist_ff[SHORT_WINDOW-1] : '0;
   assign long_leave  = long_full  ? hist_ff[LONG_WINDOW-1]  : '0;

   // Running sums add the new price and drop the oldest one in one step.
   assign short_total_in = short_total_ff + S_TOT_W'(price_in) - S_TOT_W'(short_leave);
   assign long_total_in  = long_total_ff  + L_TOT_W'(price_in) - L_TOT_W'(long_leave);
   assign seen_in        = (seen_ff == CNT_W'(HIST_DEPTH)) ? seen_ff : seen_ff + CNT_W'(1);

   // History shift line, no reset: an entry is only read after it was written.
   always_ff @(posedge clock) begin
      if (load) begin
         hist_ff[0] <= price_in;
         for (int i = 1; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   // Sums and item count.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_total_ff <= '0;
         long_total_ff  <= '0;
         seen_ff        <= '0;
      end else if (load) begin
         short_total_ff <= short_total_in;
         long_total_ff  <= long_total_in;
         seen_ff        <= seen_in;
      end
   end

   // Effective counts for the division-free comparison.
   assign short_total = short_total_ff;
   assign long_total  = long_total_ff;
   assign n_short     = short_full ? NS_W'(SHORT_WINDOW) : seen_ff[NS_W-1:0];
   assign n_long      = long_full  ? NL_W'(LONG_WINDOW)  : seen_ff[NL_W-1:0];
   assign warm        = long_full;

endmodule

// ===== rtl/sma_cmp.sv =====
// Average comparison by cross-multiplication and crossover decision.
// Keeps the relation of the previous item to detect a cross.
// Depends on sma_pkg.
module sma_cmp #(
   parameter int SHORT_WINDOW = 20,
   parameter int LONG_WINDOW  = 50
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            load,
   input  logic [sma_pkg::PRICE_W+$clog2(SHORT_WINDOW+1)-1:0] short_total,
   input  logic [sma_pkg::PRICE_W+$clog2(LONG_WINDOW+1)-1:0]  long_total,
   input  logic [$clog2(SHORT_WINDOW+1)-1:0]               n_short,
   input  logic [$clog2(LONG_WINDOW+1)-1:0]                n_long,
   input  logic                                            warm,
   output sma_pkg::signal_type                             signal
);
   import sma_pkg::*;

   localparam int NS_W    = $clog2(SHORT_WINDOW + 1);
   localparam int NL_W    = $clog2(LONG_WINDOW + 1);
   localparam int S_TOT_W = PRICE_W + NS_W;
   localparam int L_TOT_W = PRICE_W + NL_W;
   localparam int PROD_W  = S_TOT_W + NL_W;

   logic [PROD_W-1:0] lhs;
   logic [PROD_W-1:0] rhs;
   relation_type      relation;
   relation_type      prev_rel_ff;

   // short_total / n_short against long_total / n_long without a divider.
   assign lhs = PROD_W'(short_total) * PROD_W'(n_long);
   assign rhs = PROD_W'(long_total) * PROD_W'(n_short);

   always_comb begin
      priority if (lhs < rhs) begin
         relation = REL_LESS;
      end else if (lhs > rhs) begin
         relation = REL_GREATER;
      end else begin
         relation = REL_EQUAL;
      end
   end

   // A cross is reported only once the long window has filled.
   always_comb begin
      signal = SIG_NONE;
      if (warm) begin
         priority if (prev_rel_ff == REL_LESS && relation != REL_LESS) begin
            signal = SIG_BUY;
         end else if (prev_rel_ff == REL_GREATER && relation != REL_GREATER) begin
            signal = SIG_SELL;
         end else begin
            signal = SIG_NONE;
         end
      end
   end

   // Relation remembered for the next item, also during warm-up.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_rel_ff <= REL_EQUAL;
      end else if (load) begin
         prev_rel_ff <= relation;
      end
   end

endmodule

// ===== rtl/sma_crossover_detector_core.sv =====
// Moving-average crossover detector, top level.
// Throughput: one item per cycle while the result side takes results; the window sums
// update in the accept cycle, and the cross-multiply compare runs once the result register
// is free, loading its result into the result register.
// Reset (synchronous, active high) clears sums, count, relation and valid flags;
// the price history is not cleared and needs no clearing pass.
module sma_crossover_detector_core #(
   parameter int SHORT_WINDOW = 20,
   parameter int LONG_WINDOW  = 50
) (
   input logic       clock,
   input logic       reset,
   sma_req_if.sink   req_bus,
   sma_rsp_if.source rsp_bus
);
   import sma_pkg::*;

   localparam int NS_W    = $clog2(SHORT_WINDOW + 1);
   localparam int NL_W    = $clog2(LONG_WINDOW + 1);
   localparam int S_TOT_W = PRICE_W + NS_W;
   localparam int L_TOT_W = PRICE_W + NL_W;

   logic                   accept;
   logic                   out_free;
   logic                   stage_move;
   logic                   stage_valid_ff;
   logic                   stage_valid_in;
   logic [PRICE_W-1:0]     stage_price_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   signal_type             rsp_signal_ff;
   logic [PRICE_W-1:0]     rsp_price_ff;
   logic [SHORT_SUM_W-1:0] rsp_short_ff;
   logic [LONG_SUM_W-1:0]  rsp_long_ff;
   logic [S_TOT_W-1:0]     short_total;
   logic [L_TOT_W-1:0]     long_total;
   logic [NS_W-1:0]        n_short;
   logic [NL_W-1:0]        n_long;
   logic                   warm;
   signal_type             signal;
   logic [S_TOT_W+SHORT_SUM_W-1:0] short_ext;
   logic [L_TOT_W+LONG_SUM_W-1:0]  long_ext;

   // Handshake: the result register is free when empty or being taken.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign stage_move    = stage_valid_ff && out_free;
   assign req_bus.ready = !stage_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign stage_valid_in = accept ? 1'b1 : (stage_move ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = stage_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // Window state advances at accept; it then describes the item in the compare stage.
   sma_win #(
      .SHORT_WINDOW (SHORT_WINDOW),
      .LONG_WINDOW  (LONG_WINDOW)
   ) u_win (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .price_in    (req_bus.price),
      .short_total (short_total),
      .long_total  (long_total),
      .n_short     (n_short),
      .n_long      (n_long),
      .warm        (warm)
   );

   sma_cmp #(
      .SHORT_WINDOW (SHORT_WINDOW),
      .LONG_WINDOW  (LONG_WINDOW)
   ) u_cmp (
      .clock       (clock),
      .reset       (reset),
      .load        (stage_move),
      .short_total (short_total),
      .long_total  (long_total),
      .n_short     (n_short),
      .n_long      (n_long),
      .warm        (warm),
      .signal      (signal)
   );

   // Sums are reported at the fixed field widths.
   assign short_ext = (S_TOT_W + SHORT_SUM_W)'(short_total);
   assign long_ext  = (L_TOT_W + LONG_SUM_W)'(long_total);

   // Valid flags of the compare stage and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_price_ff <= req_bus.price;
      end
      if (stage_move) begin
         rsp_signal_ff <= signal;
         rsp_price_ff  <= stage_price_ff;
         rsp_short_ff  <= short_ext[SHORT_SUM_W-1:0];
         rsp_long_ff   <= long_ext[LONG_SUM_W-1:0];
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.signal    = rsp_signal_ff;
   assign rsp_bus.price_out = rsp_price_ff;
   assign rsp_bus.short_sum = rsp_short_ff;
   assign rsp_bus.long_sum  = rsp_long_ff;

endmodule

// ===== rtl/sma_chk.sv =====
// Port-level checker for the crossover detector, bound to the top level.
// Watches both channels over time; depends on sma_pkg.
module sma_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [sma_pkg::PRICE_W-1:0]  req_price,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input sma_pkg::signal_type          rsp_signal,
   input logic [sma_pkg::PRICE_W-1:0]  rsp_price_out
);
   import sma_pkg::*;

   signal_type last_sig_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Signal of the last delivered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sig_ff <= SIG_NONE;
      end else if (rsp_take) begin
         last_sig_ff <= rsp_signal;
      end
   end

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // With the result register empty the block always takes a new item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while no result is pending");

   // An item that is accepted and then meets a free output path comes out with its own price.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_take ##1 (!rsp_valid || rsp_ready)) |=>
      (rsp_valid && rsp_price_out == $past(req_price, 2)))
      else $error("price not delivered after two cycles");

   // Only the defined signal codes appear.
   a_sig_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_signal == SIG_NONE || rsp_signal == SIG_BUY ||
                     rsp_signal == SIG_SELL))
      else $error("undefined signal code");

   // A cross cannot repeat in the same direction on the very next item.
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_signal != SIG_NONE |-> last_sig_ff != rsp_signal)
      else $error("same crossover signaled on two items in a row");

endmodule

bind sma_crossover_detector_core sma_chk u_sma_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_price     (req_bus.price),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_signal    (rsp_bus.signal),
   .rsp_price_out (rsp_bus.price_out)
);

// ===== tb/sma_crossover_detector_core_tb.sv =====
// Self-checking testbench for the moving-average crossover detector.
// A directed table is followed by shaped random price sequences. Every result is checked
// against an in-bench predictor, or against its own row for typed rows. Depends on sma_pkg, sma_if.sv and the core RTL.
module sma_crossover_detector_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sma_pkg::*;

   localparam int SHORT_LEN   = 20;
   localparam int LONG_LEN    = 50;
   localparam int HIST_DEPTH  = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
   localparam int ITEM_TARGET = 1100;
   localparam int QUIET_TAIL  = 150;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DIR_ROWS    = 24;
   localparam int PEND_DEPTH  = 64;

   // One result item as the block should produce it.
   typedef struct {
      signal_type             signal;
      logic [PRICE_W-1:0]     price;
      logic [SHORT_SUM_W-1:0] short_sum;
      logic [LONG_SUM_W-1:0]  long_sum;
   } crossover_type;

   // One row of the directed table; typed rows carry their result.
   typedef struct packed {
      logic [PRICE_W-1:0]     price;
      logic                   typed;
      signal_type             signal;
      logic [SHORT_SUM_W-1:0] short_sum;
      logic [LONG_SUM_W-1:0]  long_sum;
   } dir_row_type;

   typedef enum {SEG_TREND, SEG_FLAT, SEG_NOISE, SEG_EXTREME, SEG_SQUARE} segment_kind_type;

   // Extremes and the warm-up: the averages stay equal for twenty items, then move apart.
   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{32'hFFFF_FFFF, 1'b1, SIG_NONE, 37'h0_FFFF_FFFF, 38'h0_FFFF_FFFF},
      '{32'h0000_0000, 1'b1, SIG_NONE, 37'h0_FFFF_FFFF, 38'h0_FFFF_FFFF},
      '{32'hFFFF_FFFF, 1'b1, SIG_NONE, 37'h1_FFFF_FFFE, 38'h1_FFFF_FFFE},
      '{32'h0000_0000, 1'b1, SIG_NONE, 37'h1_FFFF_FFFE, 38'h1_FFFF_FFFE},
      '{32'h8000_0000, 1'b1, SIG_NONE, 37'h2_7FFF_FFFE, 38'h2_7FFF_FFFE},
      '{32'h0000_0001, 1'b0, SIG_NONE, '0, '0},
      '{32'h0001_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h7FFF_FFFF, 1'b0, SIG_NONE, '0, '0},
      '{32'h5555_5555, 1'b0, SIG_NONE, '0, '0},
      '{32'hAAAA_AAAA, 1'b0, SIG_NONE, '0, '0},
      '{32'h0000_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0000_8000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0010_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0020_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0030_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0040_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0050_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0060_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0070_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0080_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'hFFFF_FFFF, 1'b0, SIG_NONE, '0, '0},
      '{32'hFFFF_FFFF, 1'b0, SIG_NONE, '0, '0},
      '{32'h0000_0000, 1'b0, SIG_NONE, '0, '0},
      '{32'h0000_0000, 1'b0, SIG_NONE, '0, '0}
   };

   logic clock;
   logic reset;

   sma_req_if req_bus ();
   sma_rsp_if rsp_bus ();

   sma_crossover_detector_core #(
      .SHORT_WINDOW(SHORT_LEN),
      .LONG_WINDOW (LONG_LEN)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Predictor state: price history, exact window sums and the last relation.
   logic [PRICE_W-1:0] hist_mem [HIST_DEPTH];
   int                 hist_wr;
   logic [63:0]        short_acc;
   logic [63:0]        long_acc;
   int                 seen;
   relation_type       last_rel;

   // Expected results in order, held in a ring with free-running counts.
   crossover_type pend_mem [PEND_DEPTH];
   int            pend_wr;
   int            pend_rd;
   int            error_count;
   int            items_sent;
   int            cycle_count;
   int            rsp_hold_cycles;
   bit            idle_on;
   bit            gaps_on;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Any run that outlives the limit has hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Advance the predictor by one price and return the result it implies.
   function automatic crossover_type advance_crossover(input logic [PRICE_W-1:0] price);
      crossover_type res;
      logic [63:0]   n_short;
      logic [63:0]   n_long;
      logic [63:0]   lhs;
      logic [63:0]   rhs;
      relation_type  rel;
      if (seen >= SHORT_LEN) begin
         short_acc = short_acc + price - hist_mem[(hist_wr + HIST_DEPTH - SHORT_LEN) % HIST_DEPTH];
      end else begin
         short_acc = short_acc + price;
      end
      if (seen >= LONG_LEN) begin
         long_acc = long_acc + price - hist_mem[(hist_wr + HIST_DEPTH - LONG_LEN) % HIST_DEPTH];
      end else begin
         long_acc = long_acc + price;
      end
      hist_mem[hist_wr] = price;
      hist_wr = (hist_wr + 1) % HIST_DEPTH;
      if (seen < HIST_DEPTH) begin
         seen++;
      end
      // Compare the averages by cross-multiplying with the effective window counts.
      n_short = 64'((seen < SHORT_LEN) ? seen : SHORT_LEN);
      n_long  = 64'((seen < LONG_LEN) ? seen : LONG_LEN);
      lhs = short_acc * n_long;
      rhs = long_acc * n_short;
      rel = (lhs < rhs) ? REL_LESS : ((lhs > rhs) ? REL_GREATER : REL_EQUAL);
      res.signal = SIG_NONE;
      if (seen >= LONG_LEN) begin
         if (last_rel == REL_LESS && rel != REL_LESS) begin
            res.signal = SIG_BUY;
         end else if (last_rel == REL_GREATER && rel != REL_GREATER) begin
            res.signal = SIG_SELL;
         end
      end
      last_rel = rel;
      res.price     = price;
      res.short_sum = short_acc[SHORT_SUM_W-1:0];
      res.long_sum  = long_acc[LONG_SUM_W-1:0];
      return res;
   endfunction

   function automatic logic [PRICE_W-1:0] clamp_price(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > 64'sh0000_0000_FFFF_FFFF) begin
         return '1;
      end
      return v[PRICE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR cycle %0d: %s: got 0x%0h, expected 0x%0h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   // Offer one price, wait for it to be taken, then record its expected result.
   task automatic offer_price(input dir_row_type row);
      crossover_type predicted;
      if (gaps_on && idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.price <= row.price;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = advance_crossover(row.price);
      if (row.typed) begin
         predicted.signal    = row.signal;
         predicted.price     = row.price;
         predicted.short_sum = row.short_sum;
         predicted.long_sum  = row.long_sum;
      end
      pend_mem[pend_wr % PEND_DEPTH] = predicted;
      pend_wr++;
      items_sent++;
   endtask

   // Check each accepted result against the oldest expected one.
   always @(posedge clock) begin : check_results
      crossover_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pend_wr == pend_rd) begin
            report_mismatch("result item with nothing expected",
                            64'(rsp_bus.price_out), '0);
         end else begin
            want = pend_mem[pend_rd % PEND_DEPTH];
            pend_rd++;
            if (rsp_bus.signal !== want.signal) begin
               report_mismatch("signal", 64'(rsp_bus.signal), 64'(want.signal));
            end
            if (rsp_bus.price_out !== want.price) begin
               report_mismatch("price_out", 64'(rsp_bus.price_out), 64'(want.price));
            end
            if (rsp_bus.short_sum !== want.short_sum) begin
               report_mismatch("short_sum", 64'(rsp_bus.short_sum), 64'(want.short_sum));
            end
            if (rsp_bus.long_sum !== want.long_sum) begin
               report_mismatch("long_sum", 64'(rsp_bus.long_sum), 64'(want.long_sum));
            end
         end
      end
   end

   // Result side: runs of ready, random stalls, and a long hold when asked for one.
   initial begin : drive_rsp_ready
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // Price side: reset, the directed table, then shaped random sequences.
   initial begin : drive_prices
      dir_row_type        row;
      segment_kind_type   kind;
      int                 seg_index;
      int                 seg_len;
      int                 half_period;
      longint             level;
      longint             slope;
      int unsigned        noise;
      logic [PRICE_W-1:0] next_price;
      logic [PRICE_W-1:0] level_a;
      logic [PRICE_W-1:0] level_b;
      bit                 use_const;

      for (int i = 0; i < HIST_DEPTH; i++) begin
         hist_mem[i] = '0;
      end
      hist_wr         = 0;
      short_acc       = '0;
      long_acc        = '0;
      seen            = 0;
      last_rel        = REL_EQUAL;
      error_count     = 0;
      items_sent      = 0;
      rsp_hold_cycles = 0;
      idle_on         = 1'b1;
      gaps_on         = 1'b1;
      level           = 64'sh0000_0000_0064_0000;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.price <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      for (int r = 0; r < DIR_ROWS; r++) begin
         offer_price(DIRECTED_ROWS[r]);
      end

      // Random part, built from segments that drive the averages across each other.
      seg_index = 0;
      while (items_sent < ITEM_TARGET) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: kind = SEG_TREND;
            8, 9, 10:               kind = SEG_FLAT;
            11, 12:                 kind = SEG_NOISE;
            13, 14, 15:             kind = SEG_EXTREME;
            default:                kind = SEG_SQUARE;
         endcase
         seg_len = $urandom_range(20, 60);

         // Hold off the result side while prices keep coming, so the input stalls.
         if (seg_index == 2) begin
            kind            = SEG_TREND;
            seg_len         = 60;
            gaps_on         = 1'b0;
            rsp_hold_cycles = 120;
         end

         // Pause prices until every expected result has been seen.
         if (seg_index == 5 || seg_index == 11) begin
            req_bus.valid <= 1'b0;
            while (pend_wr != pend_rd) @(posedge clock);
         end

         // Segment setup.
         if (kind == SEG_TREND && $urandom_range(0, 3) == 0) begin
            level = $urandom_range(0, 32'hFFFF_FFFF);
         end
         slope = $urandom_range(0, 32'h0004_0000);
         if ($urandom_range(0, 1) == 1) begin
            slope = -slope;
         end
         noise       = $urandom_range(0, 32'h0002_0000);
         use_const   = ($urandom_range(0, 1) == 1);
         half_period = $urandom_range(5, 30);
         level_a     = clamp_price(level + $urandom_range(0, 32'h0040_0000));
         level_b     = clamp_price(level - $urandom_range(0, 32'h0040_0000));
         if (kind == SEG_FLAT) begin
            seg_len    = $urandom_range(50, 70);
            next_price = ($urandom_range(0, 2) == 0) ? $urandom() : clamp_price(level);
         end else if (kind == SEG_NOISE) begin
            seg_len = $urandom_range(5, 30);
         end else if (kind == SEG_EXTREME) begin
            seg_len    = $urandom_range(50, 60);
            next_price = ($urandom_range(0, 1) == 1) ? '1 : '0;
         end else if (kind == SEG_SQUARE) begin
            seg_len = 4 * half_period;
         end

         for (int i = 0; i < seg_len; i++) begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL) begin
               idle_on = 1'b0;
            end
            case (kind)
               SEG_TREND: begin
                  next_price = clamp_price(level + $urandom_range(0, noise));
                  level      = clamp_price(level + slope);
               end
               SEG_NOISE: begin
                  next_price = $urandom();
               end
               SEG_EXTREME: begin
                  if (!use_const) begin
                     case ($urandom_range(0, 3))
                        0:       next_price = '0;
                        1:       next_price = 32'h0000_0001;
                        2:       next_price = 32'hFFFF_FFFE;
                        default: next_price = '1;
                     endcase
                  end
               end
               SEG_SQUARE: begin
                  next_price = ((i / half_period) % 2 == 0) ? level_a : level_b;
               end
               default: begin
               end
            endcase
            row       = '0;
            row.price = next_price;
            offer_price(row);
         end
         if (kind != SEG_TREND) begin
            level = next_price;
         end
         seg_index++;
      end

      // Drain and let the pipeline settle.
      req_bus.valid <= 1'b0;
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
